// File: rtl/core/roberts_cross_edge_magnitude_unit_assert.svh
// Assertion macros for the Roberts cross edge magnitude unit.
`ifndef ROBERTS_CROSS_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define ROBERTS_CROSS_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define RCEM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcem check failed");
`define RCEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcem check failed");
`else
`define RCEM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RCEM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/rcem_pkg.sv
// Shared types and constants for the Roberts cross edge magnitude unit.
`default_nettype none

package rcem_pkg;

    localparam int PIX_W            = 8;
    localparam int LINE_W_BITS      = 11;
    localparam int MIN_WIDTH        = 2;
    localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RESET = 11'd512;
    localparam int ENERGY_W         = 17;
    localparam int ROOT_W           = (ENERGY_W + 1) / 2;
    localparam int MAG_W            = 8;
    localparam logic [MAG_W-1:0] MAG_MAX = 8'hFF;

    typedef struct packed {
        logic accept;
        logic load;
        logic square;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic root_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/rcem_pixel_if.sv
// Pixel input channel.
`default_nettype none

interface rcem_pixel_if;
    import rcem_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcem_mag_if.sv
// Gradient magnitude output channel.
`default_nettype none

interface rcem_mag_if;
    import rcem_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             row_end;

    modport source (output valid, output magnitude, output row_end, input ready);
    modport sink   (input valid, input magnitude, input row_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcem_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rcem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rcem_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module rcem_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rcem_pkg::ENERGY_W-1:0] i_value,
    output logic                              o_done,
    output logic      [rcem_pkg::ROOT_W-1:0]   o_root
);
    import rcem_pkg::*;

    localparam int VAL_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [VAL_W-1:0] r_val, n_val;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic r_done, n_done;
    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_val[VAL_W-1 -: 2]};
        trial  = {{(SH_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        diff   = rem_sh - trial;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_val  = VAL_W'(i_value);
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(ROOT_W);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_val = {r_val[VAL_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = diff[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/core/rcem_datapath.sv
// Datapath: line store, neighbor registers, differences, squares, root and output register.
`default_nettype none

module rcem_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [rcem_pkg::LINE_W_BITS-1:0] i_cfg_wr_data,
    input  wire logic [rcem_pkg::PIX_W-1:0]      i_pixel,
    input  wire logic                            i_frame_start,
    input  wire rcem_pkg::t_cmd                  i_cmd,
    output rcem_pkg::t_stat                      o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic      [rcem_pkg::MAG_W-1:0]      o_magnitude,
    output logic                                 o_row_end
);
    import rcem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > LINE_W_BITS) ? WW : LINE_W_BITS;

    logic [LINE_W_BITS-1:0] r_line_width;
    logic [AW-1:0] r_col_count;
    logic r_past_first;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upper_left;
    logic [PIX_W-1:0] r_pix;
    logic [AW-1:0] r_col;
    logic r_emit;
    logic r_row_end;
    logic [PIX_W-1:0] r_d1;
    logic [PIX_W-1:0] r_d2;
    logic r_out_valid;
    logic [MAG_W-1:0] r_magnitude;
    logic r_out_row_end;

    logic [CW-1:0] lw_ext;
    logic [WW-1:0] width;
    logic [AW-1:0] cc0;
    logic pf0;
    logic wrap;
    logic [AW-1:0] col;
    logic pf1;
    logic [WW-1:0] col_inc;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] d2;
    logic [2*PIX_W-1:0] sq1;
    logic [2*PIX_W-1:0] sq2;
    logic [ENERGY_W-1:0] energy;
    logic root_done;
    logic [ROOT_W-1:0] root;

    always_comb begin
        lw_ext = CW'(r_line_width);
        if (lw_ext < CW'(MIN_WIDTH)) begin
            width = WW'(MIN_WIDTH);
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            width = WW'(MAX_WIDTH);
        end else begin
            width = lw_ext[WW-1:0];
        end
        cc0     = i_frame_start ? '0 : r_col_count;
        pf0     = i_frame_start ? 1'b0 : r_past_first;
        wrap    = WW'(cc0) >= width;
        col     = wrap ? '0 : cc0;
        pf1     = wrap | pf0;
        col_inc = WW'(col) + WW'(1);
    end

    rcem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load),
        .i_wr_addr (r_col),
        .i_wr_data (r_pix),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (col),
        .o_rd_data (up)
    );

    always_comb begin
        d1     = (r_upper_left > r_pix) ? (r_upper_left - r_pix) : (r_pix - r_upper_left);
        d2     = (r_left > up) ? (r_left - up) : (up - r_left);
        sq1    = r_d1 * r_d1;
        sq2    = r_d2 * r_d2;
        energy = ENERGY_W'(sq1) + ENERGY_W'(sq2);
    end

    rcem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.square),
        .i_value (energy),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col_count  <= '0;
            r_past_first <= 1'b0;
            r_left       <= '0;
            r_upper_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_line_width <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (col_inc >= width) begin
                    r_col_count  <= '0;
                    r_past_first <= 1'b1;
                end else begin
                    r_col_count  <= col_inc[AW-1:0];
                    r_past_first <= pf1;
                end
            end
            if (i_cmd.load) begin
                r_upper_left <= up;
                r_left       <= r_pix;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.accept) begin
            r_pix     <= i_pixel;
            r_col     <= col;
            r_emit    <= pf1 && (col != '0);
            r_row_end <= WW'(col) == (width - WW'(1));
        end
        if (i_cmd.load) begin
            r_d1 <= d1;
            r_d2 <= d2;
        end
        if (i_cmd.out_load) begin
            r_magnitude   <= root[ROOT_W-1] ? MAG_MAX : root[MAG_W-1:0];
            r_out_row_end <= r_row_end;
        end
    end

    always_comb begin
        o_stat.emit      = r_emit;
        o_stat.root_done = root_done;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_magnitude = r_magnitude;
    assign o_row_end   = r_out_row_end;

endmodule

`default_nettype wire

// File: rtl/core/rcem_ctrl.sv
// Controller state machine sequencing one pixel word at a time.
`default_nettype none

module rcem_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rcem_pkg::t_stat i_stat,
    output rcem_pkg::t_cmd       o_cmd
);
    import rcem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SQUARE,
        S_ROOT,
        S_HOLD
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.square   = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_stat.emit ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                if (i_stat.root_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/roberts_cross_edge_magnitude_unit.sv
// Top level of the Roberts cross edge magnitude unit.
//
//   channel   direction  payload                   handshake
//   i_pix     in         pixel[7:0], frame_start   valid/ready
//   o_mag     out        magnitude[7:0], row_end   valid/ready
//   i_cfg_*   in         line_width[10:0]          write enable only
//
// A pixel without a result passes the accept and line store read/write steps.
// A pixel with a result adds the square and root steps of the nine-step root unit.
// The output register holds a result while the next pixel is taken; a stalled
// output holds the controller before the root is stored. Reset is synchronous and
// needs no clearing pass; the line store holds no valid bits.
`default_nettype none

`include "roberts_cross_edge_magnitude_unit_assert.svh"

module roberts_cross_edge_magnitude_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [rcem_pkg::LINE_W_BITS-1:0] i_cfg_wr_data,
    rcem_pixel_if.sink                           i_pix,
    rcem_mag_if.source                           o_mag
);
    import rcem_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    rcem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rcem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (o_mag.ready),
        .o_out_valid   (o_mag.valid),
        .o_magnitude   (o_mag.magnitude),
        .o_row_end     (o_mag.row_end)
    );

    assign i_pix.ready = w_in_ready;

    `RCEM_ASSERT_NEXT(a_word_gap, i_clk, i_rst_n, i_pix.valid && i_pix.ready, !i_pix.ready)
    `RCEM_ASSERT_SAME(a_out_free, i_clk, i_rst_n, w_cmd.out_load, !o_mag.valid || o_mag.ready)
    `RCEM_ASSERT_SAME(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))

endmodule

`default_nettype wire
